@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for clocked assertions, reset-gated on arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication from an antecedent to a consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/dds_pkg.sv @@
// ----------------------------------------------------------------------------
// dds_pkg
// Types, constants and calendar tables shared by the date stepper modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dds_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned DNUM_W  = 22;
	localparam int unsigned YMOD_W  = 7;   // year mod 100
	localparam int unsigned CENT_W  = 7;   // year / 100 for valid years
	localparam int unsigned QUOT_W  = 8;   // year / 100 for any 14-bit year
	localparam int unsigned DOY_W   = 9;

	// year / 100 as (year * 5243) >> 19, exact for all 14-bit years
	localparam int unsigned DIV100_MUL_W = 13;
	localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
	localparam int unsigned DIV100_SHIFT = 19;

	localparam logic [YEAR_W-1:0]  MAX_YEAR          = 14'd9999;
	localparam logic [YEAR_W-1:0]  CUTOVER_YEAR      = 14'd1582;
	localparam logic [MONTH_W-1:0] CUTOVER_MONTH     = 4'd10;
	localparam logic [DAY_W-1:0]   CUTOVER_LAST_OLD  = 5'd4;
	localparam logic [DAY_W-1:0]   CUTOVER_FIRST_NEW = 5'd15;

	localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
	localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
	localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;
	localparam logic [YMOD_W-1:0]  RESET_YMOD  = 7'd0;
	localparam logic [CENT_W-1:0]  RESET_CENT  = 7'd20;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_NEXT = 2'd1,
		CMD_PREV = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_LIMIT   = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} cmd_item_t;

	typedef struct packed {
		cmd_item_t          item;
		logic [YMOD_W-1:0]  ymod;
		logic [QUOT_W-1:0]  quot;
	} load_req_t;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic [YMOD_W-1:0]  ymod;
		logic [CENT_W-1:0]  cent;
		logic               leap;
		status_t            status;
	} date_res_t;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic [DNUM_W-1:0]  dnum;
		logic               leap;
		status_t            status;
	} out_item_t;

	// leap from year mod 100 and the low bits of the century
	function automatic logic leap_of(input logic [YMOD_W-1:0] ymod, input logic [1:0] cent_lo);
		return (ymod[1:0] == 2'd0) && ((ymod != '0) || (cent_lo == 2'd0));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (month)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month,
			input logic leap);
		logic [DOY_W-1:0] base;
		case (month)
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + {{(DOY_W-1){1'b0}}, (leap && (month > 4'd2))};
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/dds_year_split.sv @@
// ----------------------------------------------------------------------------
// dds_year_split
// Input register and split of the offered year into century and year mod 100.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dds_year_split (
	input  wire logic              clk,
	input  wire logic              load_s1,
	input  wire logic              load_s2,
	input  wire dds_pkg::cmd_item_t item,
	output dds_pkg::load_req_t     req_s2
);
	import dds_pkg::*;

	cmd_item_t                        item_s1;
	logic [YEAR_W+DIV100_MUL_W-1:0]  prod;
	logic [QUOT_W-1:0]               quot;
	logic [YMOD_W-1:0]               q100;
	logic [YMOD_W-1:0]               rem;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		prod = {{DIV100_MUL_W{1'b0}}, item_s1.year} * {{YEAR_W{1'b0}}, DIV100_MUL};
		quot = prod[DIV100_SHIFT +: QUOT_W];
		// only the remainder mod 128 is needed, it is below 100
		q100 = YMOD_W'({quot, 6'b0} + {1'b0, quot, 5'b0} + {4'b0, quot, 2'b0});
		rem  = item_s1.year[YMOD_W-1:0] - q100;
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			req_s2.item <= item_s1;
			req_s2.ymod <= rem;
			req_s2.quot <= quot;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/dds_date_state.sv @@
// ----------------------------------------------------------------------------
// dds_date_state
// Current date register: load check, next-day and previous-day stepping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dds_date_state (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load_s3,
	input  wire dds_pkg::load_req_t req_s2,
	output dds_pkg::date_res_t     res_s3
);
	import dds_pkg::*;

	logic [DAY_W-1:0]   day_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;
	logic [YMOD_W-1:0]  ymod_q;
	logic [CENT_W-1:0]  cent_q;

	logic [DAY_W-1:0]   nxt_day;
	logic [MONTH_W-1:0] nxt_month;
	logic [YEAR_W-1:0]  nxt_year;
	logic [YMOD_W-1:0]  nxt_ymod;
	logic [CENT_W-1:0]  nxt_cent;
	status_t            nxt_status;

	logic cur_leap;
	logic ld_leap;
	logic ld_valid;
	logic at_cutover_old;
	logic at_cutover_new;

	assign cur_leap = leap_of(ymod_q, cent_q[1:0]);
	assign ld_leap  = leap_of(req_s2.ymod, req_s2.quot[1:0]);

	assign at_cutover_old = (year_q == CUTOVER_YEAR) && (month_q == CUTOVER_MONTH)
		&& (day_q == CUTOVER_LAST_OLD);
	assign at_cutover_new = (year_q == CUTOVER_YEAR) && (month_q == CUTOVER_MONTH)
		&& (day_q == CUTOVER_FIRST_NEW);

	always_comb begin
		ld_valid = (req_s2.item.year != '0) && (req_s2.item.year <= MAX_YEAR)
			&& (req_s2.item.month >= 4'd1) && (req_s2.item.month <= 4'd12)
			&& (req_s2.item.day != '0)
			&& (req_s2.item.day <= month_len(req_s2.item.month, ld_leap))
			&& !((req_s2.item.year == CUTOVER_YEAR) && (req_s2.item.month == CUTOVER_MONTH)
				&& (req_s2.item.day > CUTOVER_LAST_OLD)
				&& (req_s2.item.day < CUTOVER_FIRST_NEW));
	end

	always_comb begin
		nxt_day    = day_q;
		nxt_month  = month_q;
		nxt_year   = year_q;
		nxt_ymod   = ymod_q;
		nxt_cent   = cent_q;
		nxt_status = ST_OK;
		case (cmd_t'(req_s2.item.command))
			CMD_LOAD: begin
				if (ld_valid) begin
					nxt_day   = req_s2.item.day;
					nxt_month = req_s2.item.month;
					nxt_year  = req_s2.item.year;
					nxt_ymod  = req_s2.ymod;
					nxt_cent  = req_s2.quot[CENT_W-1:0];
				end else begin
					nxt_status = ST_INVALID;
				end
			end
			CMD_NEXT: begin
				if ((year_q == MAX_YEAR) && (month_q == 4'd12) && (day_q == 5'd31)) begin
					nxt_status = ST_LIMIT;
				end else if (at_cutover_old) begin
					nxt_day = CUTOVER_FIRST_NEW;
				end else if (day_q >= month_len(month_q, cur_leap)) begin
					nxt_day = 5'd1;
					if (month_q == 4'd12) begin
						nxt_month = 4'd1;
						nxt_year  = year_q + 14'd1;
						if (ymod_q == 7'd99) begin
							nxt_ymod = '0;
							nxt_cent = cent_q + 7'd1;
						end else begin
							nxt_ymod = ymod_q + 7'd1;
						end
					end else begin
						nxt_month = month_q + 4'd1;
					end
				end else begin
					nxt_day = day_q + 5'd1;
				end
			end
			CMD_PREV: begin
				if ((year_q == 14'd1) && (month_q == 4'd1) && (day_q == 5'd1)) begin
					nxt_status = ST_LIMIT;
				end else if (at_cutover_new) begin
					nxt_day = CUTOVER_LAST_OLD;
				end else if (day_q <= 5'd1) begin
					if (month_q == 4'd1) begin
						// into December of the year before: always 31 days
						nxt_month = 4'd12;
						nxt_day   = 5'd31;
						nxt_year  = year_q - 14'd1;
						if (ymod_q == '0) begin
							nxt_ymod = 7'd99;
							nxt_cent = cent_q - 7'd1;
						end else begin
							nxt_ymod = ymod_q - 7'd1;
						end
					end else begin
						nxt_month = month_q - 4'd1;
						nxt_day   = month_len(month_q - 4'd1, cur_leap);
					end
				end else begin
					nxt_day = day_q - 5'd1;
				end
			end
			default: begin
				nxt_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q   <= RESET_DAY;
			month_q <= RESET_MONTH;
			year_q  <= RESET_YEAR;
			ymod_q  <= RESET_YMOD;
			cent_q  <= RESET_CENT;
		end else if (load_s3) begin
			day_q   <= nxt_day;
			month_q <= nxt_month;
			year_q  <= nxt_year;
			ymod_q  <= nxt_ymod;
			cent_q  <= nxt_cent;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			res_s3.day    <= nxt_day;
			res_s3.month  <= nxt_month;
			res_s3.year   <= nxt_year;
			res_s3.ymod   <= nxt_ymod;
			res_s3.cent   <= nxt_cent;
			res_s3.leap   <= leap_of(nxt_ymod, nxt_cent[1:0]);
			res_s3.status <= nxt_status;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/dds_day_count.sv @@
// ----------------------------------------------------------------------------
// dds_day_count
// Proleptic day number from the reported date, in two register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dds_day_count (
	input  wire logic               clk,
	input  wire logic               load_s4,
	input  wire logic               load_s5,
	input  wire dds_pkg::date_res_t  res_s3,
	output dds_pkg::out_item_t      out_s5
);
	import dds_pkg::*;

	date_res_t          res_s4;
	logic [DNUM_W-1:0]  yterm_s4;
	logic [DNUM_W-1:0]  rest_s4;

	logic [YEAR_W-1:0]  yb;
	logic [CENT_W-1:0]  ybc;
	logic [DNUM_W-1:0]  yterm;
	logic [DNUM_W-1:0]  rest;

	always_comb begin
		yb  = res_s3.year - 14'd1;
		// (year-1)/100: one less than the century when year is a multiple of 100
		ybc = (res_s3.ymod == '0) ? (res_s3.cent - 7'd1) : res_s3.cent;
		yterm = DNUM_W'({{(DNUM_W-YEAR_W){1'b0}}, yb} * 22'd365)
			+ {{(DNUM_W-YEAR_W+2){1'b0}}, yb[YEAR_W-1:2]};
		// may wrap below zero here; the final sum is never negative
		rest = {{(DNUM_W-DOY_W){1'b0}}, days_before(res_s3.month, res_s3.leap)}
			+ {{(DNUM_W-DAY_W){1'b0}}, res_s3.day} - 22'd1
			+ {{(DNUM_W-CENT_W+2){1'b0}}, ybc[CENT_W-1:2]}
			- {{(DNUM_W-CENT_W){1'b0}}, ybc};
	end

	always_ff @(posedge clk) begin
		if (load_s4) begin
			res_s4   <= res_s3;
			yterm_s4 <= yterm;
			rest_s4  <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s5) begin
			out_s5.day    <= res_s4.day;
			out_s5.month  <= res_s4.month;
			out_s5.year   <= res_s4.year;
			out_s5.dnum   <= yterm_s4 + rest_s4;
			out_s5.leap   <= res_s4.leap;
			out_s5.status <= res_s4.status;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/date_day_stepper_core.sv @@
// ----------------------------------------------------------------------------
// date_day_stepper_core
// Gregorian date register with load, next-day and previous-day commands.
//
//   port group   dir  tdata fields (low bit up)            tuser
//   s_axis       in   day_in, month_in, year_in            command
//   m_axis       out  day_out, month_out, year_out,        status
//                     day_number, is_leap
//
// One item per cycle while m_axis is not stalled; a result passes stages s1
// (input), s2 (year split), s3 (date), s4 and s5 (day number). The date register
// loop is combinational; the year split and day-number sum are pipelined round it.
// Reset: date 1 January 2000, pipeline empty.
// A stalled m_axis holds the pipe; s_axis_tready drops only once all five
// stages hold items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module date_day_stepper_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // day_in[4:0], month_in[8:5], year_in[22:9]
	input  wire logic [1:0]  s_axis_tuser,   // command[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,   // day_out[4:0], month_out[8:5], year_out[22:9],
	                                         // day_number[44:23], is_leap[45]
	output logic [1:0]       m_axis_tuser    // status[1:0]
);
	import dds_pkg::*;

	localparam int unsigned NSTAGE = 5;

	logic [NSTAGE:1]   vld_q;
	logic [NSTAGE:1]   feed;
	logic [NSTAGE+1:1] rdy;
	logic [NSTAGE:1]   load;

	cmd_item_t  item;
	load_req_t  req_s2;
	date_res_t  res_s3;
	out_item_t  out_s5;

	assign feed = {vld_q[NSTAGE-1:1], s_axis_tvalid};

	always_comb begin
		rdy[NSTAGE+1] = m_axis_tready;
		for (int k = NSTAGE; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign load = feed & rdy[NSTAGE:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NSTAGE; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= feed[k];
				end
			end
		end
	end

	assign item.command = s_axis_tuser;
	assign item.day     = s_axis_tdata[4:0];
	assign item.month   = s_axis_tdata[8:5];
	assign item.year    = s_axis_tdata[22:9];

	dds_year_split u_split (
		.clk     (clk),
		.load_s1 (load[1]),
		.load_s2 (load[2]),
		.item    (item),
		.req_s2  (req_s2)
	);

	dds_date_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.load_s3 (load[3]),
		.req_s2  (req_s2),
		.res_s3  (res_s3)
	);

	dds_day_count u_count (
		.clk     (clk),
		.load_s4 (load[4]),
		.load_s5 (load[5]),
		.res_s3  (res_s3),
		.out_s5  (out_s5)
	);

	assign s_axis_tready = rdy[1];
	assign m_axis_tvalid = vld_q[NSTAGE];
	assign m_axis_tdata  = {2'b00, out_s5.leap, out_s5.dnum, out_s5.year,
		out_s5.month, out_s5.day};
	assign m_axis_tuser  = out_s5.status;

	`ASSERT_IMPLIES(a_ready_when_out_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

	`ASSERT_IMPLIES(a_date_in_range, m_axis_tvalid, (m_axis_tdata[4:0] != 5'd0) && (m_axis_tdata[8:5] != 4'd0) && (m_axis_tdata[8:5] <= 4'd12) && (m_axis_tdata[22:9] != 14'd0), "reported date out of range")

	`ASSERT_IMPLIES(a_limit_at_edge, m_axis_tvalid && (m_axis_tuser == ST_LIMIT), ((m_axis_tdata[22:9] == 14'd1) && (m_axis_tdata[8:5] == 4'd1) && (m_axis_tdata[4:0] == 5'd1)) || ((m_axis_tdata[22:9] == MAX_YEAR) && (m_axis_tdata[8:5] == 4'd12) && (m_axis_tdata[4:0] == 5'd31)), "limit status away from range edge")

	`ASSERT_IMPLIES(a_leap_needs_div4, m_axis_tvalid && (m_axis_tdata[10:9] != 2'd0), !m_axis_tdata[45], "leap flag on year not divisible by four")

endmodule

`default_nettype wire
